// ===== rtl/cad_script_lexer_defines.svh =====
// Assertion macros shared by the lexer checker.
`ifndef CAD_SCRIPT_LEXER_DEFINES_SVH
`define CAD_SCRIPT_LEXER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define CADL_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cad_script_lexer check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define CADL_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cad_script_lexer check failed");

`endif

// ===== rtl/cadl_pkg.sv =====
`default_nettype none
package cadl_pkg;

    // Token kinds
    localparam logic [4:0] KIND_END    = 5'd0;
    localparam logic [4:0] KIND_NUM    = 5'd1;
    localparam logic [4:0] KIND_STR    = 5'd2;
    localparam logic [4:0] KIND_IDENT  = 5'd3;
    localparam logic [4:0] KIND_LE     = 5'd4;
    localparam logic [4:0] KIND_GE     = 5'd5;
    localparam logic [4:0] KIND_EQ     = 5'd6;
    localparam logic [4:0] KIND_NE     = 5'd7;
    localparam logic [4:0] KIND_AND    = 5'd8;
    localparam logic [4:0] KIND_OR     = 5'd9;
    localparam logic [4:0] KIND_SLASH  = 5'd24;
    localparam logic [4:0] KIND_CHAR   = 5'd29;
    localparam logic [4:0] KIND_UNTERM = 5'd30;
    localparam logic [4:0] KIND_BADCH  = 5'd31;

    // Lexer modes
    typedef enum logic [13:0] {
        MODE_IDLE  = 14'b00000000000001,
        MODE_SLASH = 14'b00000000000010,
        MODE_LINE  = 14'b00000000000100,
        MODE_BLOCK = 14'b00000000001000,
        MODE_BSTAR = 14'b00000000010000,
        MODE_STR   = 14'b00000000100000,
        MODE_ESC   = 14'b00000001000000,
        MODE_INT   = 14'b00000010000000,
        MODE_FRAC  = 14'b00000100000000,
        MODE_EXP   = 14'b00001000000000,
        MODE_EXPD  = 14'b00010000000000,
        MODE_DOT   = 14'b00100000000000,
        MODE_IDENT = 14'b01000000000000,
        MODE_OP    = 14'b10000000000000
    } mode_t;

    // One result record
    typedef struct packed {
        logic [4:0]  kind;
        logic [19:0] start;
        logic [19:0] length;
        logic [19:0] line;
        logic [7:0]  ch;
        logic        last;
    } rec_t;

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= 8'h30) && (b <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] b);
        return ((b >= 8'h61) && (b <= 8'h7a)) || ((b >= 8'h41) && (b <= 8'h5a));
    endfunction

    function automatic logic is_space(input logic [7:0] b);
        return (b == 8'h20) || ((b >= 8'd9) && (b <= 8'd13));
    endfunction

    function automatic logic ident_first(input logic [7:0] b);
        return is_alpha(b) || (b == 8'h5f) || (b == 8'h24);
    endfunction

    function automatic logic ident_more(input logic [7:0] b);
        return is_alpha(b) || is_digit(b) || (b == 8'h5f);
    endfunction

    // Punctuation lookup: bit 5 flags a match, bits 4:0 give the kind
    function automatic logic [5:0] punct_lookup(input logic [7:0] b);
        logic [5:0] r;
        case (b)
            8'h28:   r = {1'b1, 5'd10};
            8'h29:   r = {1'b1, 5'd11};
            8'h7b:   r = {1'b1, 5'd12};
            8'h7d:   r = {1'b1, 5'd13};
            8'h5b:   r = {1'b1, 5'd14};
            8'h5d:   r = {1'b1, 5'd15};
            8'h2c:   r = {1'b1, 5'd16};
            8'h3b:   r = {1'b1, 5'd17};
            8'h3a:   r = {1'b1, 5'd18};
            8'h3f:   r = {1'b1, 5'd19};
            8'h3d:   r = {1'b1, 5'd20};
            8'h2b:   r = {1'b1, 5'd21};
            8'h2d:   r = {1'b1, 5'd22};
            8'h2a:   r = {1'b1, 5'd23};
            8'h2f:   r = {1'b1, 5'd24};
            8'h25:   r = {1'b1, 5'd25};
            8'h3c:   r = {1'b1, 5'd26};
            8'h3e:   r = {1'b1, 5'd27};
            8'h21:   r = {1'b1, 5'd28};
            default: r = 6'd0;
        endcase
        return r;
    endfunction

    // Two-character operator kind, KIND_END when the pair is no operator
    function automatic logic [4:0] pair_kind(input logic [7:0] a, input logic [7:0] b);
        logic [4:0] k;
        k = KIND_END;
        if (a == 8'h3c && b == 8'h3d) k = KIND_LE;
        if (a == 8'h3e && b == 8'h3d) k = KIND_GE;
        if (a == 8'h3d && b == 8'h3d) k = KIND_EQ;
        if (a == 8'h21 && b == 8'h3d) k = KIND_NE;
        if (a == 8'h26 && b == 8'h26) k = KIND_AND;
        if (a == 8'h7c && b == 8'h7c) k = KIND_OR;
        return k;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/cadl_step.sv =====
`default_nettype none
module cadl_step #(
    parameter int P = 20
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          fire,
    input  wire logic          op_in,
    input  wire logic [7:0]    byte_in,
    output cadl_pkg::rec_t     rec_a,
    output cadl_pkg::rec_t     rec_b,
    output logic               put_a,
    output logic               put_b
);

    localparam logic [P-1:0] ONE = {{(P-1){1'b0}}, 1'b1};

    cadl_pkg::mode_t mode_reg, mode_next, i_mode;
    logic [7:0]   held_reg, held_next;
    logic [P-1:0] off_reg, off_next, off_inc;
    logic [P-1:0] line_reg, line_next;
    logic [P-1:0] begin_reg, begin_next;
    logic         err_reg, err_next;

    logic           i_nl, i_held, i_put, i_fail;
    cadl_pkg::rec_t i_rec;
    logic           use_idle;
    logic [5:0]     pl;
    logic [5:0]     hl;
    logic [4:0]     pk;

    function automatic logic [19:0] fit(input logic [P-1:0] v);
        logic [P+19:0] w;
        w = {20'd0, v};
        return w[19:0];
    endfunction

    function automatic logic [P-1:0] sat(input logic [P-1:0] v);
        return (&v) ? v : v + ONE;
    endfunction

    function automatic cadl_pkg::rec_t mk(input logic [4:0] k, input logic [P-1:0] s,
                                          input logic [P-1:0] n, input logic [P-1:0] ln,
                                          input logic [7:0] c);
        cadl_pkg::rec_t r;
        r.kind   = k;
        r.start  = fit(s);
        r.length = fit(n);
        r.line   = fit(ln);
        r.ch     = c;
        r.last   = 1'b0;
        return r;
    endfunction

    function automatic logic [P-1:0] span(input logic [P-1:0] e, input logic [P-1:0] b);
        return (e >= b) ? e - b : '0;
    endfunction

    assign off_inc = sat(off_reg);
    assign pl      = cadl_pkg::punct_lookup(byte_in);
    assign hl      = cadl_pkg::punct_lookup(held_reg);
    assign pk      = cadl_pkg::pair_kind(held_reg, byte_in);

    // Classify a byte seen between tokens
    always_comb
    begin
        i_mode = cadl_pkg::MODE_IDLE;
        i_nl   = 1'b0;
        i_held = 1'b0;
        i_put  = 1'b0;
        i_fail = 1'b0;
        i_rec  = mk(pl[4:0], off_reg, ONE, line_reg, 8'd0);
        if (byte_in == 8'h0a)
        begin
            i_nl = 1'b1;
        end
        else if (cadl_pkg::is_space(byte_in))
        begin
            i_mode = cadl_pkg::MODE_IDLE;
        end
        else if (byte_in == 8'h2f)
        begin
            i_mode = cadl_pkg::MODE_SLASH;
        end
        else if (byte_in == 8'h22)
        begin
            i_mode = cadl_pkg::MODE_STR;
        end
        else if (cadl_pkg::is_digit(byte_in))
        begin
            i_mode = cadl_pkg::MODE_INT;
        end
        else if (byte_in == 8'h2e)
        begin
            i_mode = cadl_pkg::MODE_DOT;
        end
        else if (cadl_pkg::ident_first(byte_in))
        begin
            i_mode = cadl_pkg::MODE_IDENT;
        end
        else if (byte_in == 8'h3c || byte_in == 8'h3e || byte_in == 8'h3d ||
                 byte_in == 8'h21 || byte_in == 8'h26 || byte_in == 8'h7c)
        begin
            i_mode = cadl_pkg::MODE_OP;
            i_held = 1'b1;
        end
        else if (pl[5])
        begin
            i_put = 1'b1;
        end
        else
        begin
            i_put  = 1'b1;
            i_fail = 1'b1;
            i_rec  = mk(cadl_pkg::KIND_BADCH, off_reg, ONE, line_reg, byte_in);
        end
    end

    // Mode transition and result records for one transaction
    always_comb
    begin
        mode_next  = mode_reg;
        held_next  = held_reg;
        off_next   = off_inc;
        line_next  = line_reg;
        begin_next = begin_reg;
        err_next   = err_reg;
        put_a      = 1'b0;
        put_b      = 1'b0;
        use_idle   = 1'b0;
        rec_a      = mk(cadl_pkg::KIND_END, off_reg, '0, line_reg, 8'd0);
        rec_b      = rec_a;
        if (op_in)
        begin
            if (!err_reg)
            begin
                unique case (mode_reg)
                    cadl_pkg::MODE_SLASH:
                    begin
                        put_a = 1'b1;
                        rec_a = mk(cadl_pkg::KIND_SLASH, begin_reg, ONE, line_reg, 8'd0);
                    end
                    cadl_pkg::MODE_STR, cadl_pkg::MODE_ESC:
                    begin
                        put_a = 1'b1;
                        rec_a = mk(cadl_pkg::KIND_UNTERM, begin_reg,
                                   span(off_reg, begin_reg), line_reg, 8'd0);
                    end
                    cadl_pkg::MODE_INT, cadl_pkg::MODE_FRAC,
                    cadl_pkg::MODE_EXP, cadl_pkg::MODE_EXPD:
                    begin
                        put_a = 1'b1;
                        rec_a = mk(cadl_pkg::KIND_NUM, begin_reg,
                                   span(off_reg, begin_reg), line_reg, 8'd0);
                    end
                    cadl_pkg::MODE_DOT:
                    begin
                        put_a = 1'b1;
                        rec_a = mk(cadl_pkg::KIND_BADCH, begin_reg, ONE, line_reg, 8'h2e);
                    end
                    cadl_pkg::MODE_IDENT:
                    begin
                        put_a = 1'b1;
                        rec_a = mk(cadl_pkg::KIND_IDENT, begin_reg,
                                   span(off_reg, begin_reg), line_reg, 8'd0);
                    end
                    cadl_pkg::MODE_OP:
                    begin
                        put_a = 1'b1;
                        if (hl[5])
                            rec_a = mk(hl[4:0], begin_reg, ONE, line_reg, 8'd0);
                        else
                            rec_a = mk(cadl_pkg::KIND_BADCH, begin_reg, ONE, line_reg,
                                       held_reg);
                    end
                    default:
                    begin
                        put_a = 1'b0;
                    end
                endcase
            end
            put_b      = 1'b1;
            rec_b      = mk(cadl_pkg::KIND_END, off_reg, '0, line_reg, 8'd0);
            mode_next  = cadl_pkg::MODE_IDLE;
            held_next  = 8'd0;
            off_next   = '0;
            line_next  = ONE;
            begin_next = '0;
            err_next   = 1'b0;
        end
        else if (!err_reg)
        begin
            unique case (mode_reg)
                cadl_pkg::MODE_IDLE:
                begin
                    use_idle = 1'b1;
                end
                cadl_pkg::MODE_SLASH:
                begin
                    if (byte_in == 8'h2f)
                        mode_next = cadl_pkg::MODE_LINE;
                    else if (byte_in == 8'h2a)
                        mode_next = cadl_pkg::MODE_BLOCK;
                    else
                    begin
                        put_a    = 1'b1;
                        rec_a    = mk(cadl_pkg::KIND_SLASH, begin_reg, ONE, line_reg, 8'd0);
                        use_idle = 1'b1;
                    end
                end
                cadl_pkg::MODE_LINE:
                begin
                    if (byte_in == 8'h0a)
                    begin
                        line_next = sat(line_reg);
                        mode_next = cadl_pkg::MODE_IDLE;
                    end
                end
                cadl_pkg::MODE_BLOCK, cadl_pkg::MODE_BSTAR:
                begin
                    if (mode_reg == cadl_pkg::MODE_BSTAR && byte_in == 8'h2f)
                        mode_next = cadl_pkg::MODE_IDLE;
                    else
                    begin
                        if (byte_in == 8'h0a)
                            line_next = sat(line_reg);
                        mode_next = (byte_in == 8'h2a) ? cadl_pkg::MODE_BSTAR
                                                       : cadl_pkg::MODE_BLOCK;
                    end
                end
                cadl_pkg::MODE_STR:
                begin
                    if (byte_in == 8'h22)
                    begin
                        put_a     = 1'b1;
                        rec_a     = mk(cadl_pkg::KIND_STR, begin_reg,
                                       span(off_inc, begin_reg), line_reg, 8'd0);
                        mode_next = cadl_pkg::MODE_IDLE;
                    end
                    else if (byte_in == 8'h5c)
                        mode_next = cadl_pkg::MODE_ESC;
                    else
                    begin
                        put_a = 1'b1;
                        rec_a = mk(cadl_pkg::KIND_CHAR, off_reg, ONE, line_reg, byte_in);
                        if (byte_in == 8'h0a)
                            line_next = sat(line_reg);
                    end
                end
                cadl_pkg::MODE_ESC:
                begin
                    put_a = 1'b1;
                    rec_a = mk(cadl_pkg::KIND_CHAR, (off_reg != '0) ? off_reg - ONE : '0,
                               ONE + ONE, line_reg,
                               (byte_in == 8'h6e) ? 8'd10 :
                               (byte_in == 8'h74) ? 8'd9 : byte_in);
                    if (byte_in == 8'h0a)
                        line_next = sat(line_reg);
                    mode_next = cadl_pkg::MODE_STR;
                end
                cadl_pkg::MODE_INT, cadl_pkg::MODE_FRAC,
                cadl_pkg::MODE_EXP, cadl_pkg::MODE_EXPD:
                begin
                    if (mode_reg == cadl_pkg::MODE_EXP &&
                        (byte_in == 8'h2b || byte_in == 8'h2d || cadl_pkg::is_digit(byte_in)))
                        mode_next = cadl_pkg::MODE_EXPD;
                    else if (mode_reg != cadl_pkg::MODE_EXP && cadl_pkg::is_digit(byte_in))
                        mode_next = mode_reg;
                    else if (mode_reg == cadl_pkg::MODE_INT && byte_in == 8'h2e)
                        mode_next = cadl_pkg::MODE_FRAC;
                    else if ((mode_reg == cadl_pkg::MODE_INT || mode_reg == cadl_pkg::MODE_FRAC)
                             && (byte_in == 8'h65 || byte_in == 8'h45))
                        mode_next = cadl_pkg::MODE_EXP;
                    else
                    begin
                        put_a    = 1'b1;
                        rec_a    = mk(cadl_pkg::KIND_NUM, begin_reg,
                                      span(off_reg, begin_reg), line_reg, 8'd0);
                        use_idle = 1'b1;
                    end
                end
                cadl_pkg::MODE_DOT:
                begin
                    if (cadl_pkg::is_digit(byte_in))
                        mode_next = cadl_pkg::MODE_FRAC;
                    else
                    begin
                        put_a     = 1'b1;
                        rec_a     = mk(cadl_pkg::KIND_BADCH, begin_reg, ONE, line_reg, 8'h2e);
                        err_next  = 1'b1;
                        mode_next = cadl_pkg::MODE_IDLE;
                    end
                end
                cadl_pkg::MODE_IDENT:
                begin
                    if (!cadl_pkg::ident_more(byte_in))
                    begin
                        put_a    = 1'b1;
                        rec_a    = mk(cadl_pkg::KIND_IDENT, begin_reg,
                                      span(off_reg, begin_reg), line_reg, 8'd0);
                        use_idle = 1'b1;
                    end
                end
                cadl_pkg::MODE_OP:
                begin
                    put_a = 1'b1;
                    if (pk != cadl_pkg::KIND_END)
                    begin
                        rec_a     = mk(pk, begin_reg, ONE + ONE, line_reg, 8'd0);
                        mode_next = cadl_pkg::MODE_IDLE;
                    end
                    else if (hl[5])
                    begin
                        rec_a    = mk(hl[4:0], begin_reg, ONE, line_reg, 8'd0);
                        use_idle = 1'b1;
                    end
                    else
                    begin
                        rec_a     = mk(cadl_pkg::KIND_BADCH, begin_reg, ONE, line_reg,
                                       held_reg);
                        err_next  = 1'b1;
                        mode_next = cadl_pkg::MODE_IDLE;
                    end
                end
                default:
                begin
                    use_idle = 1'b1;
                end
            endcase
            // Lex the byte afresh from the idle mode
            if (use_idle)
            begin
                mode_next  = i_mode;
                begin_next = off_reg;
                if (i_held)
                    held_next = byte_in;
                if (i_nl)
                    line_next = sat(line_reg);
                if (i_fail)
                    err_next = 1'b1;
                put_b = i_put;
                rec_b = i_rec;
            end
        end
        rec_b.last = 1'b1;
        rec_a.last = !put_b;
    end

    // Hold lexer state between transactions
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= cadl_pkg::MODE_IDLE;
            held_reg  <= 8'd0;
            off_reg   <= '0;
            line_reg  <= ONE;
            begin_reg <= '0;
            err_reg   <= 1'b0;
        end
        else if (fire)
        begin
            mode_reg  <= mode_next;
            held_reg  <= held_next;
            off_reg   <= off_next;
            line_reg  <= line_next;
            begin_reg <= begin_next;
            err_reg   <= err_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/cadl_outq.sv =====
`default_nettype none
module cadl_outq (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push_a,
    input  wire logic           push_b,
    input  wire cadl_pkg::rec_t rec_a,
    input  wire cadl_pkg::rec_t rec_b,
    output logic                room,
    output logic                head_valid,
    input  wire logic           head_stall,
    output cadl_pkg::rec_t      head
);

    cadl_pkg::rec_t q_reg [4];
    logic [1:0] wr_reg, wr_next;
    logic [1:0] rd_reg, rd_next;
    logic [2:0] cnt_reg, cnt_next;
    logic       pop;
    logic [1:0] npush;

    assign head_valid = (cnt_reg != 3'd0);
    assign head       = q_reg[rd_reg];
    assign room       = (cnt_reg <= 3'd2);
    assign pop        = head_valid && !head_stall;
    assign npush      = {1'b0, push_a} + {1'b0, push_b};
    assign wr_next    = wr_reg + npush;
    assign rd_next    = rd_reg + {1'b0, pop};
    assign cnt_next   = cnt_reg + {1'b0, npush} - {2'b00, pop};

    // Store results in order, first record first
    always_ff @(posedge clk)
    begin
        if (push_a)
            q_reg[wr_reg] <= rec_a;
        if (push_b)
            q_reg[push_a ? wr_reg + 2'd1 : wr_reg] <= rec_b;
    end

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 2'd0;
            rd_reg  <= 2'd0;
            cnt_reg <= 3'd0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/cad_script_lexer.sv =====
// Byte-serial lexer for a C-style script language.
// Input channel: in_valid/in_stall with op (0 = source byte, 1 = end of
// source) and source_byte. A transaction is taken when in_valid is high and
// in_stall is low. Output channel: out_valid/out_stall carrying one token
// record per transaction (kind, start, length, line, char_value,
// last_of_run). One input gives zero, one or two records; last_of_run marks
// the final record of an input.
// Path: an accepted input is held in the input register; when the output
// queue has room its records are written into the queue, whose head is
// presented on the output channel.
// Throughput: one input per cycle while the output queue has room. The
// four-entry output queue drains one record per cycle when out_stall is low,
// so a run of inputs that each give two records is held back by in_stall.
// Reset clears the mode, offset, line count (to one) and the queue.
// When the receiver stalls the queue fills and in_stall rises; nothing is
// dropped. An end-of-source input flushes any pending token, emits an end
// record and returns the lexer to its reset state.
`default_nettype none
module cad_script_lexer #(
    parameter int POSITION_BITS = 20
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        op,
    input  wire logic [7:0]  source_byte,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [4:0]       token_kind,
    output logic [19:0]      token_start,
    output logic [19:0]      token_length,
    output logic [19:0]      line_number,
    output logic [7:0]       char_value,
    output logic             last_of_run
);

    logic           iv_reg, iv_next;
    logic           op_reg;
    logic [7:0]     byte_reg;
    logic           room, fire;
    logic           put_a, put_b;
    cadl_pkg::rec_t rec_a, rec_b, head;

    assign fire     = iv_reg && room;
    assign in_stall = iv_reg && !room;
    assign iv_next  = (in_valid && !in_stall) ? 1'b1 : (fire ? 1'b0 : iv_reg);

    // Capture the input transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            iv_reg <= 1'b0;
        else
            iv_reg <= iv_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            op_reg   <= op;
            byte_reg <= source_byte;
        end
    end

    cadl_step #(
        .P (POSITION_BITS)
    ) u_step (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (fire),
        .op_in   (op_reg),
        .byte_in (byte_reg),
        .rec_a   (rec_a),
        .rec_b   (rec_b),
        .put_a   (put_a),
        .put_b   (put_b)
    );

    cadl_outq u_outq (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_a     (fire && put_a),
        .push_b     (fire && put_b),
        .rec_a      (rec_a),
        .rec_b      (rec_b),
        .room       (room),
        .head_valid (out_valid),
        .head_stall (out_stall),
        .head       (head)
    );

    assign token_kind   = head.kind;
    assign token_start  = head.start;
    assign token_length = head.length;
    assign line_number  = head.line;
    assign char_value   = head.ch;
    assign last_of_run  = head.last;

endmodule
`default_nettype wire

// ===== rtl/cadl_checker.sv =====
`default_nettype none
`include "cad_script_lexer_defines.svh"
module cadl_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [4:0]  token_kind,
    input wire logic [19:0] token_start,
    input wire logic [19:0] token_length,
    input wire logic [19:0] line_number,
    input wire logic [7:0]  char_value,
    input wire logic        last_of_run
);

    logic        out_held;
    logic [73:0] out_rec;
    logic        is_char;
    logic        is_end;
    logic        is_pair;

    assign out_held = out_valid && out_stall;
    assign out_rec  = {token_kind, token_start, token_length, line_number, char_value,
                       last_of_run};
    assign is_char  = out_valid && (token_kind == cadl_pkg::KIND_CHAR);
    assign is_end   = out_valid && (token_kind == cadl_pkg::KIND_END);
    assign is_pair  = out_valid && (token_kind >= cadl_pkg::KIND_LE) &&
                      (token_kind <= cadl_pkg::KIND_OR);

    // Hold a stalled record
    `CADL_ASSERT_NEXT(a_out_hold, out_held, out_valid && $stable(out_rec))

    // Decoded string characters span one raw byte or an escape pair
    `CADL_ASSERT_NOW(a_char_len, is_char, token_length == 20'd1 || token_length == 20'd2)

    // End records close their run and carry no text
    `CADL_ASSERT_NOW(a_end_rec, is_end, last_of_run && token_length == 20'd0 && char_value == 8'd0)

    // Two-character operators are two bytes long
    `CADL_ASSERT_NOW(a_pair_len, is_pair, token_length == 20'd2)

endmodule

bind cad_script_lexer cadl_checker u_cadl_checker (.*);
`default_nettype wire

// ===== bench/tb_top.sv =====
`default_nettype none
module tb_top;

    localparam logic [4:0] KIND_PUNCT_FIRST = 5'd10;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RANDOM_ITEMS = 500;

    // Punctuation in kind order, starting at KIND_PUNCT_FIRST
    localparam string PUNCT_ORDER = "(){}[],;:?=+-*/%<>!";

    localparam bit OP_BYTE = 1'b0;
    localparam bit OP_EOS  = 1'b1;

    class lex_scoreboard;
        cadl_pkg::rec_t token_q[$];
        cadl_pkg::rec_t run_q[$];
        int errors;
        int tokens_seen;
        cadl_pkg::mode_t mode;
        logic [7:0] held;
        logic [19:0] offset, line, tbeg;
        bit latched;

        function void clear();
            mode = cadl_pkg::MODE_IDLE;
            held = 8'd0;
            offset = 20'd0;
            line = 20'd1;
            tbeg = 20'd0;
            latched = 1'b0;
        endfunction

        function logic [19:0] inc(logic [19:0] v);
            return (v == '1) ? v : v + 20'd1;
        endfunction

        function logic [19:0] span(logic [19:0] e);
            return (e >= tbeg) ? e - tbeg : 20'd0;
        endfunction

        function void put(logic [4:0] k, logic [19:0] s, logic [19:0] l, logic [7:0] c);
            cadl_pkg::rec_t r;
            if (run_q.size() < 2)
            begin
                r.kind = k;
                r.start = s;
                r.length = l;
                r.line = line;
                r.ch = c;
                r.last = 1'b0;
                run_q = {run_q, r};
            end
        endfunction

        function void bad(logic [4:0] k, logic [19:0] s, logic [19:0] l, logic [7:0] c);
            put(k, s, l, c);
            latched = 1'b1;
            mode = cadl_pkg::MODE_IDLE;
        endfunction

        function int punct_of(logic [7:0] b);
            for (int i = 0; i < PUNCT_ORDER.len(); i++)
                if (PUNCT_ORDER[i] == b)
                    return KIND_PUNCT_FIRST + i;
            return -1;
        endfunction

        // Emit a pending single operator; return 1 if it turned into an error
        function bit single_op(logic [7:0] c);
            int k;
            k = punct_of(c);
            if (c == "&" || c == "|" || k < 0)
            begin
                bad(cadl_pkg::KIND_BADCH, tbeg, 20'd1, c);
                return 1'b1;
            end
            put(k[4:0], tbeg, 20'd1, 8'd0);
            return 1'b0;
        endfunction

        function bit is_dig(logic [7:0] b);
            return b >= "0" && b <= "9";
        endfunction

        function bit is_alp(logic [7:0] b);
            return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
        endfunction

        function void idle_byte(logic [7:0] b);
            int k;
            mode = cadl_pkg::MODE_IDLE;
            tbeg = offset;
            k = punct_of(b);
            if (b == 8'h0a)
                line = inc(line);
            else if (b == " " || (b >= 8'd9 && b <= 8'd13))
                ;
            else if (b == "/")
                mode = cadl_pkg::MODE_SLASH;
            else if (b == "\"")
                mode = cadl_pkg::MODE_STR;
            else if (is_dig(b))
                mode = cadl_pkg::MODE_INT;
            else if (b == ".")
                mode = cadl_pkg::MODE_DOT;
            else if (is_alp(b) || b == "_" || b == "$")
                mode = cadl_pkg::MODE_IDENT;
            else if (b == "<" || b == ">" || b == "=" || b == "!" || b == "&" || b == "|")
            begin
                held = b;
                mode = cadl_pkg::MODE_OP;
            end
            else if (k >= 0)
                put(k[4:0], offset, 20'd1, 8'd0);
            else
                bad(cadl_pkg::KIND_BADCH, offset, 20'd1, b);
        endfunction

        function void end_token(logic [4:0] k, logic [7:0] b);
            put(k, tbeg, span(offset), 8'd0);
            idle_byte(b);
        endfunction

        function void lex_byte(logic [7:0] b);
            logic [4:0] pk;
            logic [7:0] d;
            case (mode)
                cadl_pkg::MODE_SLASH:
                    if (b == "/") mode = cadl_pkg::MODE_LINE;
                    else if (b == "*") mode = cadl_pkg::MODE_BLOCK;
                    else
                    begin
                        put(cadl_pkg::KIND_SLASH, tbeg, 20'd1, 8'd0);
                        idle_byte(b);
                    end
                cadl_pkg::MODE_LINE:
                    if (b == 8'h0a)
                    begin
                        line = inc(line);
                        mode = cadl_pkg::MODE_IDLE;
                    end
                cadl_pkg::MODE_BLOCK, cadl_pkg::MODE_BSTAR:
                    if (mode == cadl_pkg::MODE_BSTAR && b == "/")
                        mode = cadl_pkg::MODE_IDLE;
                    else
                    begin
                        if (b == 8'h0a) line = inc(line);
                        mode = (b == "*") ? cadl_pkg::MODE_BSTAR : cadl_pkg::MODE_BLOCK;
                    end
                cadl_pkg::MODE_STR:
                    if (b == "\"")
                    begin
                        put(cadl_pkg::KIND_STR, tbeg, span(inc(offset)), 8'd0);
                        mode = cadl_pkg::MODE_IDLE;
                    end
                    else if (b == "\\")
                        mode = cadl_pkg::MODE_ESC;
                    else
                    begin
                        put(cadl_pkg::KIND_CHAR, offset, 20'd1, b);
                        if (b == 8'h0a) line = inc(line);
                    end
                cadl_pkg::MODE_ESC:
                begin
                    d = (b == "n") ? 8'd10 : (b == "t") ? 8'd9 : b;
                    put(cadl_pkg::KIND_CHAR, (offset > 0) ? offset - 20'd1 : 20'd0, 20'd2, d);
                    if (b == 8'h0a) line = inc(line);
                    mode = cadl_pkg::MODE_STR;
                end
                cadl_pkg::MODE_INT:
                    if (!is_dig(b))
                    begin
                        if (b == ".") mode = cadl_pkg::MODE_FRAC;
                        else if (b == "e" || b == "E") mode = cadl_pkg::MODE_EXP;
                        else end_token(cadl_pkg::KIND_NUM, b);
                    end
                cadl_pkg::MODE_FRAC:
                    if (!is_dig(b))
                    begin
                        if (b == "e" || b == "E") mode = cadl_pkg::MODE_EXP;
                        else end_token(cadl_pkg::KIND_NUM, b);
                    end
                cadl_pkg::MODE_EXP:
                    if (b == "+" || b == "-" || is_dig(b)) mode = cadl_pkg::MODE_EXPD;
                    else end_token(cadl_pkg::KIND_NUM, b);
                cadl_pkg::MODE_EXPD:
                    if (!is_dig(b)) end_token(cadl_pkg::KIND_NUM, b);
                cadl_pkg::MODE_DOT:
                    if (is_dig(b)) mode = cadl_pkg::MODE_FRAC;
                    else bad(cadl_pkg::KIND_BADCH, tbeg, 20'd1, ".");
                cadl_pkg::MODE_IDENT:
                    if (!(is_alp(b) || is_dig(b) || b == "_"))
                        end_token(cadl_pkg::KIND_IDENT, b);
                cadl_pkg::MODE_OP:
                begin
                    pk = cadl_pkg::pair_kind(held, b);
                    if (pk != cadl_pkg::KIND_END)
                    begin
                        put(pk, tbeg, 20'd2, 8'd0);
                        mode = cadl_pkg::MODE_IDLE;
                    end
                    else if (!single_op(held))
                        idle_byte(b);
                end
                default:
                    idle_byte(b);
            endcase
        endfunction

        function void flush_pending();
            bit unused;
            case (mode)
                cadl_pkg::MODE_SLASH: put(cadl_pkg::KIND_SLASH, tbeg, 20'd1, 8'd0);
                cadl_pkg::MODE_STR, cadl_pkg::MODE_ESC:
                    put(cadl_pkg::KIND_UNTERM, tbeg, span(offset), 8'd0);
                cadl_pkg::MODE_INT, cadl_pkg::MODE_FRAC, cadl_pkg::MODE_EXP,
                cadl_pkg::MODE_EXPD:
                    put(cadl_pkg::KIND_NUM, tbeg, span(offset), 8'd0);
                cadl_pkg::MODE_DOT: put(cadl_pkg::KIND_BADCH, tbeg, 20'd1, ".");
                cadl_pkg::MODE_IDENT: put(cadl_pkg::KIND_IDENT, tbeg, span(offset), 8'd0);
                cadl_pkg::MODE_OP: unused = single_op(held);
                default: ;
            endcase
        endfunction

        // Record the tokens one accepted input transaction must produce
        function void note_input(bit eos, logic [7:0] b);
            run_q.delete();
            if (eos)
            begin
                if (!latched) flush_pending();
                put(cadl_pkg::KIND_END, offset, 20'd0, 8'd0);
                clear();
            end
            else
            begin
                if (!latched) lex_byte(b);
                offset = inc(offset);
            end
            if (run_q.size() > 0) run_q[run_q.size() - 1].last = 1'b1;
            foreach (run_q[i]) token_q = {token_q, run_q[i]};
        endfunction

        function void cmp(string name, logic [19:0] e, logic [19:0] a);
            if (e !== a)
            begin
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, e, a);
                errors++;
            end
        endfunction

        function void check_token(cadl_pkg::rec_t got);
            cadl_pkg::rec_t e;
            tokens_seen++;
            if (token_q.size() == 0)
            begin
                $display("%0t: unexpected token, expected none, got kind %0d",
                         $time, got.kind);
                errors++;
                return;
            end
            e = token_q.pop_front();
            cmp("token_kind", 20'(e.kind), 20'(got.kind));
            cmp("token_start", e.start, got.start);
            cmp("token_length", e.length, got.length);
            cmp("line_number", e.line, got.line);
            cmp("char_value", 20'(e.ch), 20'(got.ch));
            cmp("last_of_run", 20'(e.last), 20'(got.last));
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic op = OP_BYTE;
    logic [7:0] source_byte = 8'd0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [4:0] token_kind;
    logic [19:0] token_start, token_length, line_number;
    logic [7:0] char_value;
    logic last_of_run;

    lex_scoreboard sb = new();
    int send_idle_pct = 0;
    int stall_pct = 0;
    int quiet_cycles = 0;
    int bytes_sent = 0;
    int sources_sent = 0;
    logic [7:0] text_q[$];

    cad_script_lexer dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .op(op), .source_byte(source_byte),
        .out_valid(out_valid), .out_stall(out_stall),
        .token_kind(token_kind), .token_start(token_start),
        .token_length(token_length), .line_number(line_number),
        .char_value(char_value), .last_of_run(last_of_run)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Randomly hold off the token side
    always @(negedge clk)
        out_stall <= ($urandom_range(0, 99) < stall_pct);

    // Check every accepted token
    always @(posedge clk)
    begin
        cadl_pkg::rec_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got.kind = token_kind;
            got.start = token_start;
            got.length = token_length;
            got.line = line_number;
            got.ch = char_value;
            got.last = last_of_run;
            sb.check_token(got);
        end
    end

    // Abort when neither side moves for too long
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Drive one transaction and hold it until taken
    task automatic send(bit eos, logic [7:0] b);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        op = eos;
        source_byte = b;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_input(eos, b);
        if (eos) sources_sent++;
        else bytes_sent++;
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++) send(OP_BYTE, s[i]);
    endtask

    function automatic logic [7:0] pick(string s);
        return s[$urandom_range(0, s.len() - 1)];
    endfunction

    // Add one byte at the end of the pending source text
    function automatic void append_byte(logic [7:0] c);
        text_q = {text_q, c};
    endfunction

    // Append one random lexeme to the pending source text
    task automatic add_lexeme();
        string alnum;
        int n;
        alnum = "abzAZE_019en";
        case ($urandom_range(0, 12))
            0, 1:
            begin
                append_byte(pick("aZ_$xE"));
                n = $urandom_range(0, 5);
                repeat (n) append_byte(pick(alnum));
            end
            2, 3:
            begin
                if ($urandom_range(0, 5) == 0) append_byte(".");
                repeat ($urandom_range(1, 3)) append_byte(pick("0123456789"));
                if ($urandom_range(0, 1)) append_byte(pick(".."));
                repeat ($urandom_range(0, 2)) append_byte(pick("0123456789"));
                if ($urandom_range(0, 2) == 0)
                begin
                    append_byte(pick("eE"));
                    if ($urandom_range(0, 1)) append_byte(pick("+-"));
                    repeat ($urandom_range(0, 2)) append_byte(pick("0789"));
                end
            end
            4, 5:
            begin
                append_byte("\"");
                repeat ($urandom_range(0, 5))
                begin
                    case ($urandom_range(0, 5))
                        0:
                        begin
                            append_byte("\\");
                            append_byte(pick("nt\"\\q\n"));
                        end
                        1: append_byte(8'h0a);
                        default: append_byte(8'($urandom_range(0, 255)));
                    endcase
                    if (text_q[text_q.size() - 1] == "\"") void'(text_q.pop_back());
                    if (text_q[text_q.size() - 1] == "\\") append_byte("x");
                end
                if ($urandom_range(0, 9) != 0) append_byte("\"");
            end
            6, 7:
            begin
                append_byte(pick("<>=!&|"));
                if ($urandom_range(0, 1)) append_byte(pick("=&|="));
            end
            8: append_byte(pick(PUNCT_ORDER));
            9:
            begin
                append_byte("/");
                if ($urandom_range(0, 1))
                begin
                    append_byte("/");
                    repeat ($urandom_range(0, 4)) append_byte(pick("a*/ "));
                    append_byte(8'h0a);
                end
                else
                begin
                    append_byte("*");
                    repeat ($urandom_range(0, 4)) append_byte(pick("a*\n/"));
                    if ($urandom_range(0, 5) != 0)
                    begin
                        append_byte("*");
                        append_byte("/");
                    end
                end
            end
            10, 11: append_byte(pick(" \n\t\r"));
            default: append_byte(8'($urandom_range(0, 255)));
        endcase
    endtask

    initial
    begin
        int items;
        string dq;
        dq = "\"";
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: every operator but a lone =, number forms, escapes, comments, errors
        send_text({"$x_9<=>=!=&&||==(){}[],;:?+-*%<>!/.5e-3 1.2E+4 ",
                   dq, "a\\n\\t\\", dq, "\n", dq});
        send_text("/*\n*///c\na&");
        send(OP_EOS, 8'hff);
        send_text({dq, "ab\\"});
        send(OP_EOS, 8'h00);
        send_text("7.");
        send(OP_EOS, 8'h00);
        send_text("x|");
        send(OP_EOS, 8'h00);
        send(OP_BYTE, 8'hff);
        send(OP_BYTE, 8'h00);
        send(OP_EOS, 8'h00);

        // Random sources, in four idling phases
        items = 0;
        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 58 : 20) : 0;
            stall_pct = (ph == 2) ? 58 : (ph == 3) ? 20 : 0;
            while (items < (ph + 1) * RANDOM_ITEMS / 4)
            begin
                text_q.delete();
                repeat ($urandom_range(3, 12)) add_lexeme();
                foreach (text_q[i]) send(OP_BYTE, text_q[i]);
                send(OP_EOS, 8'($urandom_range(0, 255)));
                items += text_q.size() + 1;
            end
        end

        @(negedge clk);
        in_valid = 1'b0;
        while (sb.token_q.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Lexed %0d bytes in %0d sources; %0d tokens checked, %0d mismatches.",
                 bytes_sent, sources_sent, sb.tokens_seen, sb.errors);
        if (sb.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial sb.clear();
endmodule
`default_nettype wire
